// ----- rtl/core/lswc_pkg.sv -----
// Shared types and constants for the line segment window clipper.
package lswc_pkg;
    localparam int CodeBits = 4;
    localparam logic [3:0] CodeLeft   = 4'b0001;
    localparam logic [3:0] CodeRight  = 4'b0010;
    localparam logic [3:0] CodeTop    = 4'b0100;
    localparam logic [3:0] CodeBottom = 4'b1000;
    localparam int MaxMoves = 8;

    localparam logic [1:0] RegLeft   = 2'd0;
    localparam logic [1:0] RegTop    = 2'd1;
    localparam logic [1:0] RegRight  = 2'd2;
    localparam logic [1:0] RegBottom = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_MUL, ST_DIV, ST_APPLY, ST_DONE
    } t_state;
endpackage

// ----- rtl/core/line_segment_window_clipper.sv -----
// Top level of the line segment window clipper.
// Sequence: a trivial accept or reject goes from the decide state straight to done;
// each clip move passes through the multiply state, the cell-chain divider and apply,
// up to 8 moves per segment.
// Throughput: one segment at a time; busy is high from accept to result strobe.
// Reset (synchronous, active low) restores the default window 0,0..479,319.
// The receiver cannot stall: o_done pulses one cycle with the result.
module line_segment_window_clipper #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  o_done,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_visible,
    output logic [COORD_BITS-1:0] o_clip_start_x,
    output logic [COORD_BITS-1:0] o_clip_start_y,
    output logic [COORD_BITS-1:0] o_clip_end_x,
    output logic [COORD_BITS-1:0] o_clip_end_y
);
    localparam int CW = COORD_BITS;
    localparam int EW = CW + 1;          // coordinate differences
    localparam int NB = 2 * EW;          // product width
    localparam int MW = $clog2(lswc_pkg::MaxMoves + 1);

    // window registers, kept at coordinate width
    logic signed [CW-1:0] r_left, r_top, r_right, r_bottom;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= CW'(479);
            r_bottom <= CW'(319);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lswc_pkg::RegLeft:   r_left   <= i_cfg_data;
                lswc_pkg::RegTop:    r_top    <= i_cfg_data;
                lswc_pkg::RegRight:  r_right  <= i_cfg_data;
                lswc_pkg::RegBottom: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working endpoints; moved points stay inside the window so CW bits suffice
    lswc_pkg::t_state r_st, n_st;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [3:0]           r_c0, r_c1;
    logic                 r_moved;
    logic [MW-1:0]        r_moves;
    logic                 r_first, r_vert, r_neg;
    logic signed [CW-1:0] r_base, r_edge;
    logic [EW-1:0]        r_ma, r_mb, r_mc;

    function automatic logic [3:0] outcode(
        input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] l, input logic signed [CW-1:0] t,
        input logic signed [CW-1:0] r, input logic signed [CW-1:0] b);
        logic [3:0] c;
        c = '0;
        if (x < l) c |= lswc_pkg::CodeLeft;
        if (x > r) c |= lswc_pkg::CodeRight;
        if (y < t) c |= lswc_pkg::CodeTop;
        if (y > b) c |= lswc_pkg::CodeBottom;
        return c;
    endfunction

    function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
        return v[EW-1] ? EW'(-v) : v;
    endfunction

    // decide stage: pick point, edge and the three differences
    logic                 w_first, w_vert;
    logic [3:0]           w_c;
    logic signed [CW-1:0] w_px, w_py, w_ox, w_oy, w_edge;
    logic signed [EW-1:0] w_dother, w_dedge, w_daxis;
    always_comb begin
        w_first = (r_c0 != 4'd0);
        w_c  = w_first ? r_c0 : r_c1;
        w_px = w_first ? r_x0 : r_x1;
        w_py = w_first ? r_y0 : r_y1;
        w_ox = w_first ? r_x1 : r_x0;
        w_oy = w_first ? r_y1 : r_y0;
        w_vert = |(w_c & (lswc_pkg::CodeTop | lswc_pkg::CodeBottom));
        if (w_vert) begin
            w_edge   = (w_c & lswc_pkg::CodeTop) != 4'd0 ? r_top : r_bottom;
            w_dother = EW'(w_ox) - EW'(w_px);
            w_dedge  = EW'(w_edge) - EW'(w_py);
            w_daxis  = EW'(w_oy) - EW'(w_py);
        end else begin
            w_edge   = (w_c & lswc_pkg::CodeRight) != 4'd0 ? r_right : r_left;
            w_dother = EW'(w_oy) - EW'(w_py);
            w_dedge  = EW'(w_edge) - EW'(w_px);
            w_daxis  = EW'(w_ox) - EW'(w_px);
        end
    end

    // product of the registered magnitudes feeds the divider on its go cycle
    logic [NB-1:0] w_prod;
    assign w_prod = NB'(r_ma) * NB'(r_mb);

    logic          w_div_go, w_div_done;
    logic [NB-1:0] w_quot;
    lswc_divider #(.NB(NB), .DB(EW), .CELLS(4)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_div_go),
        .i_num(w_prod), .i_den(r_mc), .o_done(w_div_done), .o_quot(w_quot));

    // apply: signed quotient added to the moved coordinate
    logic signed [NB:0]   w_sq, w_sum;
    logic signed [CW-1:0] w_nx, w_ny;
    logic [3:0]           w_nc;
    always_comb begin
        w_sq  = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        w_sum = w_sq + (NB+1)'(r_base);
        if (r_vert) begin
            w_nx = CW'(w_sum);
            w_ny = r_edge;
        end else begin
            w_nx = r_edge;
            w_ny = CW'(w_sum);
        end
        w_nc = outcode(w_nx, w_ny, r_left, r_top, r_right, r_bottom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= lswc_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        w_div_go = 1'b0;
        unique case (r_st)
            lswc_pkg::ST_IDLE:   if (start) n_st = lswc_pkg::ST_DECIDE;
            lswc_pkg::ST_DECIDE: begin
                if ((r_c0 | r_c1) == 4'd0 || (r_c0 & r_c1) != 4'd0
                    || r_moves >= MW'(lswc_pkg::MaxMoves))
                    n_st = lswc_pkg::ST_DONE;
                else
                    n_st = lswc_pkg::ST_MUL;
            end
            lswc_pkg::ST_MUL: begin
                w_div_go = 1'b1;
                n_st = lswc_pkg::ST_DIV;
            end
            lswc_pkg::ST_DIV:    if (w_div_done) n_st = lswc_pkg::ST_APPLY;
            lswc_pkg::ST_APPLY:  n_st = lswc_pkg::ST_DECIDE;
            lswc_pkg::ST_DONE:   n_st = lswc_pkg::ST_IDLE;
            default:             n_st = lswc_pkg::ST_IDLE;
        endcase
    end

    assign busy = (r_st != lswc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            lswc_pkg::ST_IDLE: if (start) begin
                r_x0 <= i_start_x; r_y0 <= i_start_y;
                r_x1 <= i_end_x;   r_y1 <= i_end_y;
                r_c0 <= outcode(i_start_x, i_start_y, r_left, r_top, r_right, r_bottom);
                r_c1 <= outcode(i_end_x, i_end_y, r_left, r_top, r_right, r_bottom);
                r_moved <= 1'b0;
                r_moves <= '0;
            end
            lswc_pkg::ST_DECIDE: begin
                r_first <= w_first;
                r_vert  <= w_vert;
                r_edge  <= w_edge;
                r_base  <= w_vert ? w_px : w_py;
                r_neg   <= (w_dother[EW-1] ^ w_dedge[EW-1]) ^ w_daxis[EW-1];
                r_ma    <= mag(w_dother);
                r_mb    <= mag(w_dedge);
                r_mc    <= mag(w_daxis);
            end
            lswc_pkg::ST_MUL: ;
            lswc_pkg::ST_DIV: ;
            lswc_pkg::ST_APPLY: begin
                if (r_first) begin
                    r_x0 <= w_nx; r_y0 <= w_ny; r_c0 <= w_nc;
                end else begin
                    r_x1 <= w_nx; r_y1 <= w_ny; r_c1 <= w_nc;
                end
                r_moved <= 1'b1;
                r_moves <= r_moves + 1'b1;
            end
            lswc_pkg::ST_DONE: begin
                o_visible <= ((r_c0 | r_c1) == 4'd0) &&
                             !(r_moved && r_x0 == r_x1 && r_y0 == r_y1);
                if (((r_c0 | r_c1) == 4'd0) &&
                    !(r_moved && r_x0 == r_x1 && r_y0 == r_y1)) begin
                    o_clip_start_x <= r_x0; o_clip_start_y <= r_y0;
                    o_clip_end_x   <= r_x1; o_clip_end_y   <= r_y1;
                end else begin
                    o_clip_start_x <= '0; o_clip_start_y <= '0;
                    o_clip_end_x   <= '0; o_clip_end_y   <= '0;
                end
            end
            default: ;
        endcase
    end

    // result strobe rises in the cycle after the done state, with the result words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= (r_st == lswc_pkg::ST_DONE);
    end
endmodule

// ----- rtl/core/lswc_div_cell.sv -----
// One restoring-division cell: shifts in one dividend bit and conditionally subtracts.
module lswc_div_cell #(
    parameter int W = 34
) (
    input  logic [W-1:0] i_rem,
    input  logic         i_bit,
    input  logic [W-1:0] i_div,
    output logic [W-1:0] o_rem,
    output logic         o_q
);
    logic [W:0] w_sh;
    assign w_sh  = {i_rem, i_bit};
    assign o_q   = (w_sh >= {1'b0, i_div});
    assign o_rem = o_q ? W'(w_sh - {1'b0, i_div}) : w_sh[W-1:0];
endmodule

// ----- rtl/core/lswc_divider.sv -----
// Multi-cycle unsigned divider built from a short chain of division cells.
module lswc_divider #(
    parameter int NB = 34,
    parameter int DB = 17,
    parameter int CELLS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NB-1:0] i_num,
    input  logic [DB-1:0] i_den,
    output logic          o_done,
    output logic [NB-1:0] o_quot
);
    localparam int Steps = (NB + CELLS - 1) / CELLS;
    localparam int PW = Steps * CELLS;   // dividend padded to whole steps
    localparam int SW = $clog2(Steps + 1);
    localparam int RW = DB + 1;
    logic [PW-1:0] r_num;
    logic [NB-1:0] r_q;
    logic [RW-1:0] r_rem, r_den;
    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic [RW-1:0] w_rem [CELLS+1];
    logic [CELLS-1:0] w_q;
    assign w_rem[0] = r_rem;
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        lswc_div_cell #(.W(RW)) u_cell (
            .i_rem(w_rem[g]), .i_bit(r_num[PW-1-g]), .i_div(r_den),
            .o_rem(w_rem[g+1]), .o_q(w_q[CELLS-1-g]));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= SW'(Steps);
            r_num  <= PW'(i_num);
            r_q    <= '0;
            r_rem  <= '0;
            r_den  <= RW'(i_den);
        end else if (r_busy) begin
            r_rem <= w_rem[CELLS];
            r_num <= r_num << CELLS;
            r_q   <= (r_q << CELLS) | NB'(w_q);
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == SW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= r_busy && !i_go && (r_cnt == SW'(1));
    end
    // quotient is complete while o_done is high
    assign o_quot = r_q;
endmodule

// ----- rtl/core/lswc_checker.sv -----
// Port-level checks for the line segment window clipper, bound to the top level.
module lswc_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input logic                  o_visible,
    input logic [COORD_BITS-1:0] o_clip_start_x
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after accept");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than a cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while still busy");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_visible) |-> (o_clip_start_x == '0))
        else $error("rejected result carries coordinates");
endmodule

bind line_segment_window_clipper lswc_checker #(.COORD_BITS(COORD_BITS)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_visible(o_visible), .o_clip_start_x(o_clip_start_x));
